[design/cvs_pkg.sv]
// Shared types and constants for the class vote smoother.
package cvs_pkg;

   localparam int NUM_CLASSES    = 4;
   localparam int CLASS_W        = 2;
   localparam int SCORE_W        = 8;
   localparam int COUNT_W        = 4;
   localparam int ENTRY_W        = 3;
   localparam int LED_W          = 3;
   localparam int SUM_W          = COUNT_W + 2;
   localparam int WINDOW_DEFAULT = 10;

   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic [CLASS_W-1:0]        class_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [ENTRY_W-1:0]        entry_type;
   typedef logic [LED_W-1:0]          led_type;
   typedef logic [SUM_W-1:0]          sum_type;

   localparam count_type COUNT_MAX = '1;
   localparam entry_type ENTRY_EMPTY = '0;

   localparam led_type LED_OFF    = 3'b000;
   localparam led_type LED_CLASS0 = 3'b001;
   localparam led_type LED_CLASS1 = 3'b010;
   localparam led_type LED_CLASS2 = 3'b100;
   localparam led_type LED_CLASS3 = 3'b111;

   // Update strobes for one class lane.
   typedef struct packed {
      logic step;
      logic drop;
      logic add;
   } lane_ctrl_type;

   // One response as it sits in the output stage.
   typedef struct packed {
      class_type voted_class;
      logic      window_full;
      led_type   led_pattern;
   } rsp_type;

endpackage

[design/cvs_req_if.sv]
// Request channel: four class scores with a valid/ready handshake.
interface cvs_req_if;
   import cvs_pkg::*;

   logic      valid;
   logic      ready;
   score_type score_0;
   score_type score_1;
   score_type score_2;
   score_type score_3;

   modport source (output valid, output score_0, output score_1, output score_2,
                   output score_3, input ready);
   modport sink   (input valid, input score_0, input score_1, input score_2,
                   input score_3, output ready);
endinterface

// Response channel: voted class, window status and LED bits.
interface cvs_rsp_if;
   import cvs_pkg::*;

   logic      valid;
   logic      ready;
   class_type voted_class;
   logic      window_full;
   led_type   led_pattern;

   modport source (output valid, output voted_class, output window_full,
                   output led_pattern, input ready);
   modport sink   (input valid, input voted_class, input window_full,
                   input led_pattern, output ready);
endinterface

[design/cvs_lane.sv]
// One class lane: holds the running count of ring entries for its class.
module cvs_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  cvs_pkg::lane_ctrl_type ctrl,
   output cvs_pkg::count_type    count_next
);
   import cvs_pkg::*;

   count_type count_ff;
   count_type count_in;
   count_type dropped;

   // The count of an overwritten entry is lowered before the new one is added.
   always_comb begin
      dropped  = (ctrl.drop && count_ff != '0) ? count_ff - 1'b1 : count_ff;
      count_in = (ctrl.add && dropped != COUNT_MAX) ? dropped + 1'b1 : dropped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.step) begin
         count_ff <= count_in;
      end
   end

   assign count_next = ctrl.step ? count_in : count_ff;

endmodule

[design/cvs_merge.sv]
// Merging stage: votes over the lane counts and checks whether the ring is full.
module cvs_merge #(
   parameter int WINDOW = cvs_pkg::WINDOW_DEFAULT
) (
   input  cvs_pkg::count_type counts [cvs_pkg::NUM_CLASSES],
   output cvs_pkg::class_type voted_class,
   output logic               window_full
);
   import cvs_pkg::*;

   localparam sum_type WINDOW_SUM = SUM_W'(WINDOW);

   count_type best_count;
   sum_type   total;

   // Strict compare keeps the lowest index on equal counts.
   always_comb begin
      voted_class = '0;
      best_count  = counts[0];
      total       = SUM_W'(counts[0]);
      for (int i = 1; i < NUM_CLASSES; i++) begin
         if (best_count < counts[i]) begin
            voted_class = CLASS_W'(i);
            best_count  = counts[i];
         end
         total = total + SUM_W'(counts[i]);
      end
      window_full = (total == WINDOW_SUM);
   end

endmodule

[design/class_vote_smoother_core.sv]
// Top level of the class vote smoother: argmax, sliding-window vote, LED hold.
//
// Each request carries four signed 8-bit class scores. The block picks the
// highest-scoring class (lowest index wins a tie), writes it into a ring of
// WINDOW entries, and keeps one running count per class in four parallel
// lanes; a merging stage then votes for the most frequent class (again lowest
// index on a tie) and checks whether every ring entry has been filled. Every
// request yields exactly one response with the voted class, the full flag and
// the LED bits; the LED bits follow the voted class only once the ring is full
// and hold their last value before that (all off after reset). The response
// to a request is registered; one request is taken every cycle while ready is
// high: the ring and count update for a request completes in the cycle it is
// accepted, so the next request sees it at once. A two-entry output stage
// (response register plus skid register) lets requests keep flowing while a
// response waits; ready drops only while the skid register is occupied.
module class_vote_smoother_core #(
   parameter int WINDOW = cvs_pkg::WINDOW_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   cvs_req_if.sink   req_if,
   cvs_rsp_if.source rsp_if
);
   import cvs_pkg::*;

   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

   // Ring of class labels, stored as class plus one; zero marks an empty entry.
   entry_type         ring_ff [WINDOW];
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;
   led_type           led_hold_ff;
   led_type           led_hold_in;

   logic      out_valid_ff;
   rsp_type   out_data_ff;
   logic      skid_valid_ff;
   rsp_type   skid_data_ff;

   logic          accept;
   score_type     scores [NUM_CLASSES];
   score_type     best_score;
   class_type     best_class;
   entry_type     old_entry;
   class_type     old_class;
   logic          old_filled;
   lane_ctrl_type lane_ctrl [NUM_CLASSES];
   count_type     counts_next [NUM_CLASSES];
   class_type     voted_class;
   logic          window_full;
   rsp_type       new_rsp;
   logic          out_free;

   assign accept = req_if.valid && req_if.ready;
   assign req_if.ready = !skid_valid_ff;

   assign scores[0] = req_if.score_0;
   assign scores[1] = req_if.score_1;
   assign scores[2] = req_if.score_2;
   assign scores[3] = req_if.score_3;

   // Argmax over the scores; a strict compare keeps the lowest index on a tie.
   always_comb begin
      best_class = '0;
      best_score = scores[0];
      for (int i = 1; i < NUM_CLASSES; i++) begin
         if (scores[i] > best_score) begin
            best_class = CLASS_W'(i);
            best_score = scores[i];
         end
      end
   end

   // The entry about to be overwritten gives back its count to its class.
   assign old_entry  = ring_ff[slot_ff];
   assign old_filled = (old_entry != ENTRY_EMPTY);
   assign old_class  = CLASS_W'(old_entry - 1'b1);

   always_comb begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
         lane_ctrl[i].step = accept;
         lane_ctrl[i].drop = accept && old_filled && (old_class == CLASS_W'(i));
         lane_ctrl[i].add  = accept && (best_class == CLASS_W'(i));
      end
   end

   for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_lane
      cvs_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl[g]),
         .count_next (counts_next[g])
      );
   end

   cvs_merge #(
      .WINDOW (WINDOW)
   ) u_merge (
      .counts      (counts_next),
      .voted_class (voted_class),
      .window_full (window_full)
   );

   function automatic led_type led_code(class_type cls);
      led_type code;
      unique case (cls)
         2'd0:    code = LED_CLASS0;
         2'd1:    code = LED_CLASS1;
         2'd2:    code = LED_CLASS2;
         default: code = LED_CLASS3;
      endcase
      return code;
   endfunction

   assign led_hold_in = window_full ? led_code(voted_class) : led_hold_ff;
   assign slot_in     = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;

   assign new_rsp.voted_class = voted_class;
   assign new_rsp.window_full = window_full;
   assign new_rsp.led_pattern = led_hold_in;

   // Ring, write slot and LED state advance once per accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            ring_ff[i] <= ENTRY_EMPTY;
         end
         slot_ff     <= '0;
         led_hold_ff <= LED_OFF;
      end else if (accept) begin
         ring_ff[slot_ff] <= ENTRY_W'(best_class) + 1'b1;
         slot_ff          <= slot_in;
         led_hold_ff      <= led_hold_in;
      end
   end

   // Output stage: the response register drains first, the skid register
   // catches a response produced while the response register is stalled.
   assign out_free = !out_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : new_rsp;
      end else if (accept) begin
         skid_data_ff <= new_rsp;
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.voted_class = out_data_ff.voted_class;
   assign rsp_if.window_full = out_data_ff.window_full;
   assign rsp_if.led_pattern = out_data_ff.led_pattern;

   // The skid register is only ever filled behind a waiting response.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a response while the output is empty");

   // The write slot never leaves the ring.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= LAST_SLOT)
      else $error("write slot outside the ring");

   // Before the ring fills, the LED bits hold their value.
   a_led_hold: assert property (@(posedge clock) disable iff (reset)
      accept && !window_full |=> led_hold_ff == $past(led_hold_ff))
      else $error("LED bits changed while the ring was not full");

   // A full window always shows a lit LED pattern.
   a_full_lit: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.window_full |-> out_data_ff.led_pattern != LED_OFF)
      else $error("full window with all LEDs off");

endmodule

[dv/tb_class_vote_smoother_core.sv]
// Testbench for the class vote smoother: directed table plus random requests, scoreboarded.
`timescale 1ns / 100ps

module tb_class_vote_smoother_core;
   import cvs_pkg::*;

   localparam int WIN = WINDOW_DEFAULT;

   // Handy score extremes for the directed table.
   localparam score_type S_MIN = -128;
   localparam score_type S_MAX = 127;

   // One row of the directed table. When has_want is set, the row carries a
   // hand-written expectation; otherwise the predictor supplies it.
   typedef struct packed {
      score_type s0;
      score_type s1;
      score_type s2;
      score_type s3;
      logic      has_want;
      rsp_type   want;
   } vote_row_type;

   localparam int DIR_ROWS = 22;

   // The first rows fill the window from empty. The all-minimum and all-maximum
   // requests are ties across every class, so class zero wins. The tenth row
   // completes the window with class three holding four entries, so the LED
   // bits switch on for the first time. Later rows overwrite filled entries,
   // make the vote flip to class zero on a count tie, and wrap the write slot.
   localparam vote_row_type DIR_TABLE [0:DIR_ROWS-1] = '{
      '{S_MIN, S_MIN, S_MIN, S_MIN, 1'b1, '{2'd0, 1'b0, LED_OFF}},
      '{S_MAX, S_MAX, S_MAX, S_MAX, 1'b1, '{2'd0, 1'b0, LED_OFF}},
      '{S_MIN, S_MIN, S_MIN, S_MAX, 1'b1, '{2'd0, 1'b0, LED_OFF}},
      '{S_MIN, S_MAX, S_MIN, S_MIN, 1'b1, '{2'd0, 1'b0, LED_OFF}},
      '{S_MIN, S_MIN, S_MAX, S_MIN, 1'b1, '{2'd0, 1'b0, LED_OFF}},
      '{-8'sd3, -8'sd3, 8'sd5, 8'sd5, 1'b0, '0},
      '{-8'sd1, -8'sd1, -8'sd1, 8'sd0, 1'b0, '0},
      '{8'sd10, 8'sd20, 8'sd30, 8'sd40, 1'b0, '0},
      '{S_MIN, -8'sd127, -8'sd127, -8'sd127, 1'b0, '0},
      '{S_MIN, S_MIN, 8'sd126, S_MAX, 1'b1, '{2'd3, 1'b1, LED_CLASS3}},
      '{S_MAX, S_MIN, S_MIN, S_MIN, 1'b1, '{2'd3, 1'b1, LED_CLASS3}},
      '{8'sd0, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
      '{8'sd1, 8'sd0, 8'sd0, 8'sd0, 1'b0, '0},
      '{-8'sd2, -8'sd1, -8'sd2, -8'sd2, 1'b0, '0},
      '{8'sd0, 8'sd1, 8'sd1, -8'sd5, 1'b0, '0},
      '{8'sd50, 8'sd50, 8'sd50, 8'sd50, 1'b0, '0},
      '{8'sd0, 8'sd0, 8'sd1, 8'sd0, 1'b0, '0},
      '{-8'sd50, -8'sd60, -8'sd40, S_MIN, 1'b0, '0},
      '{S_MIN, S_MIN, -8'sd127, S_MIN, 1'b0, '0},
      '{8'sd7, 8'sd6, 8'sd9, 8'sd9, 1'b0, '0},
      '{S_MAX, S_MAX, S_MAX, S_MAX, 1'b0, '0},
      '{-8'sd1, -8'sd1, -8'sd1, -8'sd1, 1'b0, '0}
   };

   logic clock;
   logic reset;

   cvs_req_if req_ch ();
   cvs_rsp_if rsp_ch ();

   class_vote_smoother_core #(
      .WINDOW(WIN)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Idle rates in percent for the request sender and the response receiver.
   int send_idle_pct;
   int recv_idle_pct;
   int error_count;

   // Responses predicted for accepted requests, oldest first.
   rsp_type pending_votes [$];

   // Predictor state: the class ring, the write slot, the per-class tallies
   // and the latched LED bits.
   entry_type vote_window [WIN];
   logic [3:0] next_slot;
   count_type  class_tally [NUM_CLASSES];
   led_type    led_latch;

   // Class that the random biased requests favor; it changes now and then so
   // that the vote keeps moving and the LED bits go through every code.
   int favored_class;

   always #2 clock = ~clock;

   task automatic note_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic led_type led_for_class(input class_type cls);
      case (cls)
         2'd0: return LED_CLASS0;
         2'd1: return LED_CLASS1;
         2'd2: return LED_CLASS2;
         default: return LED_CLASS3;
      endcase
   endfunction

   // Advances the predictor by one request and returns the response it causes.
   function automatic rsp_type predict_vote(input score_type a, input score_type b,
                                            input score_type c, input score_type d);
      score_type scores [NUM_CLASSES];
      int        best;
      int        slot;
      int        voted;
      int        filled;
      entry_type old;
      rsp_type   res;
      scores[0] = a;
      scores[1] = b;
      scores[2] = c;
      scores[3] = d;
      // Argmax with strict compare: the lowest index wins among equal scores.
      best = 0;
      for (int i = 1; i < NUM_CLASSES; i++)
         if (scores[i] > scores[best]) best = i;
      slot = next_slot;
      if (slot >= WIN) slot = 0;
      // Retire the class of the entry being overwritten before counting the new one.
      old = vote_window[slot];
      if (old != ENTRY_EMPTY && old <= NUM_CLASSES && class_tally[old - 1] != 0)
         class_tally[old - 1] = class_tally[old - 1] - 1'b1;
      vote_window[slot] = entry_type'(best + 1);
      if (class_tally[best] != COUNT_MAX)
         class_tally[best] = class_tally[best] + 1'b1;
      next_slot = (slot + 1 >= WIN) ? 4'd0 : 4'(slot + 1);
      voted = 0;
      for (int i = 1; i < NUM_CLASSES; i++)
         if (class_tally[i] > class_tally[voted]) voted = i;
      filled = 0;
      for (int i = 0; i < NUM_CLASSES; i++)
         filled += class_tally[i];
      if (filled == WIN) led_latch = led_for_class(class_type'(voted));
      res.voted_class = class_type'(voted);
      res.window_full = (filled == WIN);
      res.led_pattern = led_latch;
      return res;
   endfunction

   // Presents one request, entered at a falling edge, and returns at the
   // falling edge after its acceptance. Valid stays high on return so that
   // back-to-back requests never lower and raise it in the same step.
   task automatic send_request(input score_type a, input score_type b,
                               input score_type c, input score_type d,
                               input logic has_want, input rsp_type want);
      rsp_type pred;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.score_0 <= a;
      req_ch.score_1 <= b;
      req_ch.score_2 <= c;
      req_ch.score_3 <= d;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // Accepted at this edge; the predictor always advances, and the table's
      // own expectation takes its place where the row supplies one.
      pred = predict_vote(a, b, c, d);
      pending_votes.push_back(has_want ? want : pred);
      @(negedge clock);
   endtask

   // Stops sending and waits until every predicted response has come back.
   task automatic drain_votes();
      req_ch.valid <= 1'b0;
      while (pending_votes.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Builds one random request. The largest share are uniform scores, some favor
   // one class so that the window settles on it, and the rest are built around ties.
   task automatic send_random_request();
      score_type s [NUM_CLASSES];
      int        mode;
      int        top;
      mode = $urandom_range(0, 9);
      if ($urandom_range(0, 19) == 0) favored_class = $urandom_range(0, NUM_CLASSES - 1);
      if (mode <= 3) begin
         for (int i = 0; i < NUM_CLASSES; i++) s[i] = score_type'($urandom_range(0, 255));
      end else if (mode <= 6) begin
         for (int i = 0; i < NUM_CLASSES; i++) s[i] = score_type'($urandom_range(0, 255));
         s[favored_class] = score_type'($urandom_range(128, 255) ^ 8'h80) ;
         if ($urandom_range(0, 3) == 0) s[favored_class] = S_MAX;
      end else begin
         // Work on order keys (score with the sign bit flipped) so that every
         // other class is at or below the shared top value.
         top = $urandom_range(0, 255);
         for (int i = 0; i < NUM_CLASSES; i++) begin
            if ($urandom_range(0, 1) == 1) s[i] = score_type'(top ^ 8'h80);
            else s[i] = score_type'($urandom_range(0, top) ^ 8'h80);
         end
      end
      send_request(s[0], s[1], s[2], s[3], 1'b0, '0);
   endtask

   // The receiver drops ready at random at the set rate.
   always @(negedge clock)
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

   // Each accepted response is compared with the oldest prediction.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_votes.size() == 0) begin
            note_error("response with no request outstanding");
         end else begin
            want = pending_votes.pop_front();
            if (rsp_ch.voted_class !== want.voted_class)
               note_error($sformatf("voted_class got %0d want %0d",
                                    rsp_ch.voted_class, want.voted_class));
            if (rsp_ch.window_full !== want.window_full)
               note_error($sformatf("window_full got %0b want %0b",
                                    rsp_ch.window_full, want.window_full));
            if (rsp_ch.led_pattern !== want.led_pattern)
               note_error($sformatf("led_pattern got %03b want %03b",
                                    rsp_ch.led_pattern, want.led_pattern));
         end
      end
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #400000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.score_0 = '0;
      req_ch.score_1 = '0;
      req_ch.score_2 = '0;
      req_ch.score_3 = '0;
      rsp_ch.ready   = 1'b0;
      error_count    = 0;
      favored_class  = 0;
      send_idle_pct  = 11;
      recv_idle_pct  = 49;
      next_slot      = '0;
      led_latch      = LED_OFF;
      for (int i = 0; i < WIN; i++) vote_window[i] = ENTRY_EMPTY;
      for (int i = 0; i < NUM_CLASSES; i++) class_tally[i] = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table, run with the first idle profile.
      for (int r = 0; r < DIR_ROWS; r++)
         send_request(DIR_TABLE[r].s0, DIR_TABLE[r].s1, DIR_TABLE[r].s2, DIR_TABLE[r].s3,
                      DIR_TABLE[r].has_want, DIR_TABLE[r].want);
      drain_votes();

      // Three random phases: slow receiver, slow sender, then full rate.
      // Between phases the sender holds off until the pipeline is empty.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 11;
               recv_idle_pct = 49;
            end
            1: begin
               send_idle_pct = 49;
               recv_idle_pct = 11;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < 183; n++) send_random_request();
         drain_votes();
      end

      repeat (10) @(posedge clock);
      if (pending_votes.size() != 0)
         note_error($sformatf("%0d responses never arrived", pending_votes.size()));
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
